FILE: hdl/vss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vss_pkg;

	localparam int unsigned SMP_W      = 24;
	localparam int unsigned MOD_W      = 8;
	localparam int unsigned WIDE_W     = SMP_W + 2;
	localparam int unsigned REG_ADDR_W = 5;
	localparam int unsigned APB_DW     = 32;

	localparam int unsigned FRAME_LEN  = 400;
	localparam int unsigned FRAME_STEP = 160;

	typedef logic [SMP_W-1:0]  smp_t;
	typedef logic [MOD_W-1:0]  fmod_t;
	typedef logic [WIDE_W-1:0] wide_t;

	localparam smp_t  MAX_SMP   = {SMP_W{1'b1}};
	localparam fmod_t SAT_MOD   = MOD_W'((2 ** SMP_W - 1) % FRAME_STEP);
	localparam fmod_t LEN_MOD   = MOD_W'(FRAME_LEN % FRAME_STEP);
	localparam wide_t STEP_WIDE = WIDE_W'(FRAME_STEP);

	localparam smp_t RST_AUDIO_LEN = 24'd0;
	localparam smp_t RST_MIN_LEN   = 24'(16000 * 5);
	localparam smp_t RST_MID_LEN   = 24'(16000 * 10);
	localparam smp_t RST_LONG_LEN  = 24'(16000 * 20);
	localparam smp_t RST_MAX_LEN   = 24'(16000 * 15);

	typedef enum logic [2:0] {
		REG_AUDIO_LEN = 3'd0,
		REG_MIN_LEN   = 3'd1,
		REG_MID_LEN   = 3'd2,
		REG_LONG_LEN  = 3'd3,
		REG_MAX_LEN   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		smp_t  audio_len;
		fmod_t audio_mod;
		smp_t  min_len;
		smp_t  mid_len;
		smp_t  long_len;
		smp_t  max_len;
	} cfg_t;

	// x mod 160 = (x[23:5] mod 5) * 32 + x[4:0]; 16 = 1 mod 5, so nibble sums
	function automatic fmod_t mod_step(input smp_t x);
		logic [6:0] s1;
		logic [4:0] s2;
		logic [4:0] m;
		s1 = 7'(x[8:5]) + 7'(x[12:9]) + 7'(x[16:13]) + 7'(x[20:17]) + 7'(x[23:21]);
		s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
		priority if (s2 >= 5'd15) begin
			m = s2 - 5'd15;
		end else if (s2 >= 5'd10) begin
			m = s2 - 5'd10;
		end else if (s2 >= 5'd5) begin
			m = s2 - 5'd5;
		end else begin
			m = s2;
		end
		return {m[2:0], x[4:0]};
	endfunction

	// (a + 400 - b) mod 160 for residues a, b
	function automatic fmod_t mod_diff(input fmod_t a, input fmod_t b);
		logic signed [9:0] t;
		t = $signed({2'b00, a}) + $signed({2'b00, LEN_MOD}) - $signed({2'b00, b});
		if (t < 0) begin
			t = t + 10'sd160;
		end else if (t >= 10'sd160) begin
			t = t - 10'sd160;
		end
		return t[MOD_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/vss_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vss_in_if;
	logic valid;
	logic ready;
	logic vad_active;

	modport source (output valid, output vad_active, input ready);
	modport sink (input valid, input vad_active, output ready);
endinterface

interface vss_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] next_offset;
	logic        seg_valid;
	logic [23:0] seg_start;
	logic [23:0] seg_end;
	logic        finished;

	modport source (output valid, output next_offset, output seg_valid, output seg_start,
		output seg_end, output finished, input ready);
	modport sink (input valid, input next_offset, input seg_valid, input seg_start,
		input seg_end, input finished, output ready);
endinterface

`default_nettype wire

FILE: hdl/vss_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module vss_regs import vss_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic wr_en;
	smp_t wr_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign wr_val = pwdata[SMP_W-1:0];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.audio_len <= RST_AUDIO_LEN;
			cfg_q.audio_mod <= '0;
			cfg_q.min_len   <= RST_MIN_LEN;
			cfg_q.mid_len   <= RST_MID_LEN;
			cfg_q.long_len  <= RST_LONG_LEN;
			cfg_q.max_len   <= RST_MAX_LEN;
		end else if (wr_en) begin
			unique case (paddr[REG_ADDR_W-1:2])
				REG_AUDIO_LEN: begin
					cfg_q.audio_len <= wr_val;
					cfg_q.audio_mod <= mod_step(wr_val);
				end
				REG_MIN_LEN:  cfg_q.min_len  <= wr_val;
				REG_MID_LEN:  cfg_q.mid_len  <= wr_val;
				REG_LONG_LEN: cfg_q.long_len <= wr_val;
				REG_MAX_LEN:  cfg_q.max_len  <= wr_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_ADDR_W-1:2])
			REG_AUDIO_LEN: prdata = APB_DW'(cfg_q.audio_len);
			REG_MIN_LEN:   prdata = APB_DW'(cfg_q.min_len);
			REG_MID_LEN:   prdata = APB_DW'(cfg_q.mid_len);
			REG_LONG_LEN:  prdata = APB_DW'(cfg_q.long_len);
			REG_MAX_LEN:   prdata = APB_DW'(cfg_q.max_len);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/vad_speech_segmenter.sv
// A decision is accepted into the input register, then passes to the result register
// once that is free. Throughput: one decision per cycle while seg_out.ready keeps up;
// the state update is one combinational step between the two registers.
// Reset (arst_n low): scan state, window and segment cleared, registers back to
// their defaults, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module vad_speech_segmenter import vss_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready,
	vss_in_if.sink                     vad_in,
	vss_out_if.source                  seg_out
);

	localparam int SW = $clog2(WINDOW + 1);
	localparam logic [SW-1:0] OPEN_TH   = SW'(WINDOW - 1);
	localparam logic [SW-1:0] GAP_SHORT = SW'(1);
	localparam logic [SW-1:0] GAP_MID   = SW'(WINDOW / 5);
	localparam smp_t          BACK      = SMP_W'(FRAME_STEP * (WINDOW - 1));

	cfg_t cfg;

	vss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic valid_s1;
	logic vad_s1;
	logic advance;
	logic take;

	// state
	logic [WINDOW-1:0] hist_q;
	logic [SW-1:0]     sum_q;
	logic              open_q;
	smp_t              so_q;
	fmod_t             so_m_q;
	smp_t              os_q;
	fmod_t             os_m_q;
	logic              done_q;

	// result register
	logic out_valid_q;
	smp_t out_next_q;
	logic out_segv_q;
	smp_t out_start_q;
	smp_t out_end_q;
	logic out_fin_q;

	// step
	logic              proc;
	logic [WINDOW-1:0] hist_n;
	logic [SW-1:0]     sum_n;
	logic              opening;
	logic              clamp_ok;
	smp_t              os_open;
	fmod_t             os_m_open;
	smp_t              seg_len;
	logic [SW-1:0]     gap;
	logic              closing;
	fmod_t             r_c;
	wide_t             end_sum;
	smp_t              e_c;
	wide_t             off_sum;
	logic              off_sat;
	smp_t              so_n;
	fmod_t             so_m_n;
	logic              end_now;
	logic              open_mid;
	smp_t              os_mid;
	fmod_t             os_m_mid;
	logic              flush;
	fmod_t             r_f;
	wide_t             fl_sum;
	smp_t              e_f;

	assign advance      = !out_valid_q || seg_out.ready;
	assign take         = valid_s1 && advance;
	assign vad_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (vad_in.ready) begin
			valid_s1 <= vad_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vad_in.ready && vad_in.valid) begin
			vad_s1 <= vad_in.vad_active;
		end
	end

	always_comb begin
		proc    = !done_q && (({2'b00, so_q} + STEP_WIDE) < {2'b00, cfg.audio_len});
		hist_n  = {hist_q[WINDOW-2:0], vad_s1};
		sum_n   = sum_q + SW'(vad_s1) - SW'(hist_q[WINDOW-1]);
		opening = !open_q && (sum_n >= OPEN_TH);

		clamp_ok  = so_q >= BACK;
		os_open   = clamp_ok ? so_q - BACK : '0;
		os_m_open = clamp_ok ? so_m_q : '0;

		seg_len = so_q - os_q;
		priority if (seg_len < cfg.mid_len) begin
			gap = GAP_SHORT;
		end else if (seg_len < cfg.long_len) begin
			gap = GAP_MID;
		end else begin
			gap = OPEN_TH;
		end
		closing = proc && open_q && (seg_len >= cfg.min_len)
			&& ((sum_n < gap) || (seg_len >= cfg.max_len));

		// rounded end: v + ((start + 400 - v) mod 160)
		r_c     = mod_diff(os_m_q, so_m_q);
		end_sum = {2'b00, so_q} + WIDE_W'(r_c);
		e_c     = (end_sum > {2'b00, MAX_SMP}) ? MAX_SMP : end_sum[SMP_W-1:0];

		off_sum = {2'b00, so_q} + (closing ? WIDE_W'(r_c) + STEP_WIDE : STEP_WIDE);
		off_sat = off_sum > {2'b00, MAX_SMP};

		if (proc) begin
			so_n   = off_sat ? MAX_SMP : off_sum[SMP_W-1:0];
			so_m_n = off_sat ? SAT_MOD : (closing ? mod_diff(os_m_q, '0) : so_m_q);
		end else begin
			so_n   = so_q;
			so_m_n = so_m_q;
		end

		end_now = !done_q && (!proc || off_sat
			|| ((off_sum + STEP_WIDE) >= {2'b00, cfg.audio_len}));

		open_mid = proc ? (open_q ? !closing : opening) : open_q;
		os_mid   = (proc && opening) ? os_open : os_q;
		os_m_mid = (proc && opening) ? os_m_open : os_m_q;

		flush  = end_now && open_mid;
		r_f    = mod_diff(os_m_mid, cfg.audio_mod);
		fl_sum = {2'b00, cfg.audio_len} + WIDE_W'(r_f);
		e_f    = (fl_sum > {2'b00, MAX_SMP}) ? MAX_SMP : fl_sum[SMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			sum_q  <= '0;
			open_q <= 1'b0;
			so_q   <= '0;
			so_m_q <= '0;
			os_q   <= '0;
			os_m_q <= '0;
			done_q <= 1'b0;
		end else if (take) begin
			if (proc) begin
				hist_q <= hist_n;
				sum_q  <= sum_n;
			end
			open_q <= open_mid && !flush;
			so_q   <= so_n;
			so_m_q <= so_m_n;
			os_q   <= os_mid;
			os_m_q <= os_m_mid;
			done_q <= done_q || end_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (seg_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_next_q <= so_n;
			out_segv_q <= closing || flush;
			out_fin_q  <= done_q || end_now;
			priority if (closing) begin
				out_start_q <= os_q;
				out_end_q   <= e_c;
			end else if (flush) begin
				out_start_q <= os_mid;
				out_end_q   <= e_f;
			end else begin
				out_start_q <= '0;
				out_end_q   <= '0;
			end
		end
	end

	assign seg_out.valid       = out_valid_q;
	assign seg_out.next_offset = out_next_q;
	assign seg_out.seg_valid   = out_segv_q;
	assign seg_out.seg_start   = out_start_q;
	assign seg_out.seg_end     = out_end_q;
	assign seg_out.finished    = out_fin_q;

endmodule

`default_nettype wire
